### rtl/core/tsg_pkg.sv
// Shared types and codes for the TDMA slot gate.
// No dependencies; imported by every module of the block.
package tsg_pkg;

  // Result verdict codes
  localparam logic [2:0] V_IDLE      = 3'd0;
  localparam logic [2:0] V_BLIND     = 3'd1;
  localparam logic [2:0] V_SEND      = 3'd2;
  localparam logic [2:0] V_WAIT_SYNC = 3'd3;
  localparam logic [2:0] V_WAIT_SLOT = 3'd4;
  localparam logic [2:0] V_WAIT_NEXT = 3'd5;

  // Register indexes on the config port
  localparam logic [2:0] R_SYNC_TIME    = 3'd0;
  localparam logic [2:0] R_OWN_SLOT     = 3'd1;
  localparam logic [2:0] R_SLOT_LENGTH  = 3'd2;
  localparam logic [2:0] R_FRAME_LENGTH = 3'd3;
  localparam logic [2:0] R_JITTER_GUARD = 3'd4;

  // Classification made by the front end
  typedef enum logic [2:0] {
    KD_IDLE  = 3'd0,
    KD_BLIND = 3'd1,
    KD_WSYNC = 3'd3,
    KD_WSLOT = 3'd4,
    KD_FRAME = 3'd6,
    KD_PEND  = 3'd7
  } kind_t;

  // Queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // Number of remainder steps in the back end
  localparam int DIV_STEPS = 64;

  typedef struct packed {
    logic [63:0] sync_time;
    logic [7:0]  own_slot;
    logic [31:0] slot_length;
    logic [31:0] frame_length;
    logic [31:0] jitter_guard;
  } cfg_t;

  // One classified word: a wait value or a dividend
  typedef struct packed {
    kind_t       kind;
    logic [63:0] val;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

### rtl/core/tsg_front.sv
// Front end: accepts time samples and classifies them in three stages.
// Depends on tsg_pkg.
module tsg_front import tsg_pkg::*; #(
  parameter int SLOT_INDEX_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] now_ns,
  input  logic        msg,
  input  qstat_t      qstat,
  output logic        push,
  output item_t       push_item
);

  localparam int IDX_W  = (SLOT_INDEX_BITS < 8) ? SLOT_INDEX_BITS : 8;
  localparam int SPAN_W = IDX_W + 32;

  logic              en;
  logic              v1_r, v2_r, v3_r;
  logic [63:0]       now1_r, now2_r;
  logic              msg1_r;
  logic [SPAN_W-1:0] span1_r;
  logic [64:0]       sum;
  logic [63:0]       start2_r;
  kind_t             kind2_r, kind3_r;
  logic [63:0]       dsync2_r, val3_r;
  kind_t             kind2_nxt, kind3_nxt;
  logic [63:0]       val3_nxt;

  // whole front stalls only when its last word cannot enter the queue
  assign en       = !(v3_r && qstat.full);
  assign in_ready = en;
  assign push     = v3_r && en;
  assign push_item = '{kind: kind3_r, val: val3_r};

  assign sum = {1'b0, cfg.sync_time} + {{(65-SPAN_W){1'b0}}, span1_r};

  // stage 2 classification
  always_comb begin
    if (!msg1_r) kind2_nxt = KD_IDLE;
    else if (cfg.sync_time == 64'd0) kind2_nxt = KD_BLIND;
    else if (now1_r < cfg.sync_time) kind2_nxt = KD_WSYNC;
    else kind2_nxt = KD_PEND;
  end

  // stage 3 classification
  always_comb begin
    kind3_nxt = kind2_r;
    val3_nxt  = 64'd0;
    case (kind2_r)
      KD_WSYNC: val3_nxt = dsync2_r;
      KD_PEND: begin
        if (now2_r < start2_r) begin
          kind3_nxt = KD_WSLOT;
          val3_nxt  = start2_r - now2_r;
        end else begin
          kind3_nxt = KD_FRAME;
          val3_nxt  = now2_r - start2_r;
        end
      end
      default: val3_nxt = 64'd0;
    endcase
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      now1_r   <= now_ns;
      msg1_r   <= msg;
      span1_r  <= SPAN_W'(cfg.own_slot[IDX_W-1:0]) * SPAN_W'(cfg.slot_length);
      now2_r   <= now1_r;
      start2_r <= sum[64] ? {64{1'b1}} : sum[63:0];
      dsync2_r <= cfg.sync_time - now1_r;
      kind2_r  <= kind2_nxt;
      kind3_r  <= kind3_nxt;
      val3_r   <= val3_nxt;
    end
  end

endmodule

### rtl/core/tsg_queue.sv
// Short register queue between front and back ends.
// Depends on tsg_pkg.
module tsg_queue import tsg_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  item_t  push_item,
  input  logic   pop,
  output item_t  head,
  output qstat_t qstat
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  assign head        = mem_r[rp_r];
  assign qstat.full  = (cnt_r == QDEPTH[QPTR_W:0]);
  assign qstat.empty = (cnt_r == '0);

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

endmodule

### rtl/core/tsg_back.sv
// Back end: pipelined frame remainder, one quotient bit per stage, then verdict.
// Depends on tsg_pkg.
module tsg_back import tsg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  item_t       head,
  input  qstat_t      qstat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  verdict,
  output logic [63:0] wait_ns
);

  logic        en;
  logic [31:0] frame, window;
  logic        vld_r  [DIV_STEPS+1];
  kind_t       kind_r [DIV_STEPS+1];
  logic [63:0] val_r  [DIV_STEPS+1];
  logic [63:0] dvd_r  [DIV_STEPS+1];
  logic [31:0] rem_r  [DIV_STEPS+1];
  logic [32:0] trial  [DIV_STEPS];
  logic [31:0] rem_nxt[DIV_STEPS];
  logic        ov_r;
  logic [2:0]  verdict_r, verdict_nxt;
  logic [63:0] wait_r, wait_nxt;

  assign en        = !ov_r || out_ready;
  assign pop       = en && !qstat.empty;
  assign out_valid = ov_r;
  assign verdict   = verdict_r;
  assign wait_ns   = wait_r;

  assign frame  = (cfg.frame_length == 32'd0) ? 32'd1 : cfg.frame_length;
  assign window = (cfg.slot_length > cfg.jitter_guard) ?
                  (cfg.slot_length - cfg.jitter_guard) : 32'd0;

  // restoring remainder step per stage
  always_comb begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial[i]   = {rem_r[i], dvd_r[i][63]};
      rem_nxt[i] = (trial[i] >= {1'b0, frame}) ?
                   32'(trial[i] - {1'b0, frame}) : trial[i][31:0];
    end
  end

  // final verdict from the last stage
  always_comb begin
    verdict_nxt = V_IDLE;
    wait_nxt    = 64'd0;
    case (kind_r[DIV_STEPS])
      KD_BLIND: verdict_nxt = V_BLIND;
      KD_WSYNC: begin
        verdict_nxt = V_WAIT_SYNC;
        wait_nxt    = val_r[DIV_STEPS];
      end
      KD_WSLOT: begin
        verdict_nxt = V_WAIT_SLOT;
        wait_nxt    = val_r[DIV_STEPS];
      end
      KD_FRAME: begin
        if (rem_r[DIV_STEPS] < window) begin
          verdict_nxt = V_SEND;
        end else begin
          verdict_nxt = V_WAIT_NEXT;
          wait_nxt    = {32'd0, frame - rem_r[DIV_STEPS]};
        end
      end
      default: verdict_nxt = V_IDLE;
    endcase
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_STEPS; i++) vld_r[i] <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= !qstat.empty;
      for (int i = 0; i < DIV_STEPS; i++) vld_r[i+1] <= vld_r[i];
      ov_r <= vld_r[DIV_STEPS];
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      kind_r[0] <= head.kind;
      val_r[0]  <= head.val;
      dvd_r[0]  <= head.val;
      rem_r[0]  <= 32'd0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        kind_r[i+1] <= kind_r[i];
        val_r[i+1]  <= val_r[i];
        dvd_r[i+1]  <= {dvd_r[i][62:0], 1'b0};
        rem_r[i+1]  <= rem_nxt[i];
      end
      verdict_r <= verdict_nxt;
      wait_r    <= wait_nxt;
    end
  end

endmodule

### rtl/core/tdma_slot_gate_unit.sv
// TDMA slot gate: from input word to result word a word passes the capture register,
// 2 front stages after capture, 1 queue entry, 65 remainder stages and 1 output register.
// Throughput one word per cycle unless stalled, set by the 64-stage remainder pipeline
// in the back end. Front and back stall independently through a four-word queue.
// Reset (rst_n, synchronous, active low) empties all stages and sets registers to
// sync_time 0, own_slot 0, slot_length 0, frame_length 1, jitter_guard 0.
module tdma_slot_gate_unit import tsg_pkg::*; #(
  parameter int SLOT_INDEX_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [63:0] now_ns, [64] message_waiting, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [2:0] verdict, [66:3] wait_ns, rest zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  cfg_t        cfg_r;
  logic        push, pop;
  item_t       push_item, head;
  qstat_t      qstat;
  logic [2:0]  verdict;
  logic [63:0] wait_ns;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_time    <= 64'd0;
      cfg_r.own_slot     <= 8'd0;
      cfg_r.slot_length  <= 32'd0;
      cfg_r.frame_length <= 32'd1;
      cfg_r.jitter_guard <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        R_SYNC_TIME:    cfg_r.sync_time    <= cfg_wdata;
        R_OWN_SLOT:     cfg_r.own_slot     <= cfg_wdata[7:0];
        R_SLOT_LENGTH:  cfg_r.slot_length  <= cfg_wdata[31:0];
        R_FRAME_LENGTH: cfg_r.frame_length <= cfg_wdata[31:0];
        R_JITTER_GUARD: cfg_r.jitter_guard <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  tsg_front #(.SLOT_INDEX_BITS(SLOT_INDEX_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .now_ns    (in_tdata[63:0]),
    .msg       (in_tdata[64]),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  tsg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  tsg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .verdict   (verdict),
    .wait_ns   (wait_ns)
  );

  assign out_tdata = {5'd0, wait_ns, verdict};

  // queue never both full and empty
  a_qstat: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty)) else $error("queue status inconsistent");

  // no push into a full queue
  a_noovf: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qstat.full)) else $error("queue overflow");

  // no pop from an empty queue
  a_noudf: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && qstat.empty)) else $error("queue underflow");

  // verdicts without a wait carry zero
  a_zwait: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (verdict == V_IDLE || verdict == V_BLIND || verdict == V_SEND)
    |-> wait_ns == 64'd0) else $error("nonzero wait on send or idle");

endmodule

### tb/tdma_slot_gate_unit_tb.sv
// Self-checking bench for the TDMA slot gate: a directed table, then random time samples.
// Depends on tsg_pkg and tdma_slot_gate_unit; results are checked against an in-bench predictor.
module tdma_slot_gate_unit_tb;
  import tsg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 69;
  localparam int WDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [63:0] cfg_wdata = '0;

  tdma_slot_gate_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct packed {
    logic [2:0]  verdict;
    logic [63:0] wait_ns;
  } verdict_t;

  // Local copy of the timetable registers
  logic [63:0] t_sync;
  logic [7:0]  t_slot;
  logic [31:0] t_slen, t_flen, t_guard;

  verdict_t verdict_q[$];
  int errors = 0;
  int send_pct = 100, recv_pct = 100;
  int wdog = 0;

  function automatic verdict_t gate_decide(logic [63:0] now, logic pend);
    verdict_t r;
    logic [64:0] start;
    logic [63:0] frame, offset, window;
    r = '0;
    if (!pend) return r;
    if (t_sync == 0) begin
      r.verdict = V_BLIND;
      return r;
    end
    start = {1'b0, t_sync} + 65'(t_slot) * 65'(t_slen);
    if (start[64]) start = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
    if (now < t_sync) begin
      r.verdict = V_WAIT_SYNC;
      r.wait_ns = t_sync - now;
    end else if (now < start[63:0]) begin
      r.verdict = V_WAIT_SLOT;
      r.wait_ns = start[63:0] - now;
    end else begin
      frame = (t_flen == 0) ? 64'd1 : 64'(t_flen);
      offset = (now - start[63:0]) % frame;
      window = (t_slen > t_guard) ? 64'(t_slen - t_guard) : 64'd0;
      if (offset < window) r.verdict = V_SEND;
      else begin
        r.verdict = V_WAIT_NEXT;
        r.wait_ns = frame - offset;
      end
    end
    return r;
  endfunction

  // Output side: random stall, compare each word with the oldest expectation
  always @(posedge clk) begin
    verdict_t e;
    out_tready <= ($urandom_range(99) < recv_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        errors++;
      end else begin
        e = verdict_q.pop_front();
        if (out_tdata[2:0] !== e.verdict) begin
          $error("verdict: expected %0d got %0d", e.verdict, out_tdata[2:0]);
          errors++;
        end
        if (out_tdata[66:3] !== e.wait_ns) begin
          $error("wait_ns: expected %0d got %0d", e.wait_ns, out_tdata[66:3]);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("tdma_slot_gate_unit: mismatch");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (addr)
      R_SYNC_TIME:    t_sync = val;
      R_OWN_SLOT:     t_slot = val[7:0];
      R_SLOT_LENGTH:  t_slen = val[31:0];
      R_FRAME_LENGTH: t_flen = val[31:0];
      R_JITTER_GUARD: t_guard = val[31:0];
      default: ;
    endcase
  endtask

  task automatic set_timetable(logic [63:0] s, logic [7:0] o, logic [31:0] l,
                               logic [31:0] f, logic [31:0] g);
    reg_write(R_SYNC_TIME, s);
    reg_write(R_OWN_SLOT, o);
    reg_write(R_SLOT_LENGTH, l);
    reg_write(R_FRAME_LENGTH, f);
    reg_write(R_JITTER_GUARD, g);
  endtask

  // Send one word; queue the expectation (typed value when given, else predicted)
  task automatic push_word(logic [63:0] now, logic pend, bit typed = 0, verdict_t tv = '0);
    while ($urandom_range(99) >= send_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, pend, now};
    verdict_q.push_back(typed ? tv : gate_decide(now, pend));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  typedef struct {
    logic [63:0] now;
    logic        pend;
    bit          typed;
    verdict_t    want;
  } row_t;

  row_t rows[$];

  initial begin
    logic [63:0] base, now;
    logic [31:0] sl, fl;
    t_sync = 0; t_slot = 0; t_slen = 0; t_flen = 1; t_guard = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset: not synchronized, so idle or blind send
    rows = '{
      '{64'd0, 1'b0, 1, '{V_IDLE, 64'd0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1, '{V_IDLE, 64'd0}},
      '{64'd0, 1'b1, 1, '{V_BLIND, 64'd0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1, '{V_BLIND, 64'd0}}
    };
    foreach (rows[i]) push_word(rows[i].now, rows[i].pend, rows[i].typed, rows[i].want);
    drain();

    // Synchronized at 1000, slot 2 of 100 ns, frame 1000, guard 10
    set_timetable(64'd1000, 8'd2, 32'd100, 32'd1000, 32'd10);
    rows = '{
      '{64'd0, 1'b1, 1, '{V_WAIT_SYNC, 64'd1000}},
      '{64'd999, 1'b1, 1, '{V_WAIT_SYNC, 64'd1}},
      '{64'd1000, 1'b1, 1, '{V_WAIT_SLOT, 64'd200}},
      '{64'd1200, 1'b1, 1, '{V_SEND, 64'd0}},
      '{64'd1289, 1'b1, 1, '{V_SEND, 64'd0}},
      '{64'd1290, 1'b1, 1, '{V_WAIT_NEXT, 64'd910}},
      '{64'd2200, 1'b1, 1, '{V_SEND, 64'd0}},
      '{64'd1290, 1'b0, 1, '{V_IDLE, 64'd0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 0, '{V_IDLE, 64'd0}}
    };
    foreach (rows[i]) push_word(rows[i].now, rows[i].pend, rows[i].typed, rows[i].want);
    drain();

    // Guard not below slot, zero frame length, slot start saturation, bad index
    set_timetable(64'hFFFF_FFFF_FFFF_FF00, 8'd255, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    reg_write(3'd7, rand64());
    rows = '{
      '{64'hFFFF_FFFF_FFFF_FF00, 1'b1, 0, '{V_IDLE, 64'd0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 0, '{V_IDLE, 64'd0}},
      '{64'd5, 1'b1, 0, '{V_IDLE, 64'd0}}
    };
    foreach (rows[i]) push_word(rows[i].now, rows[i].pend, rows[i].typed, rows[i].want);
    drain();
    set_timetable(64'd1, 8'd0, 32'd50, 32'hFFFF_FFFF, 32'd50);
    push_word(64'd1, 1'b1);
    push_word(64'd70, 1'b1);
    drain();

    // Random part: fifteen phases in five idling patterns, each with a fresh timetable
    for (int ph = 0; ph < 15; ph++) begin
      case (ph % 5)
        0: begin send_pct = 100; recv_pct = 100; end
        1: begin send_pct = 18;  recv_pct = 100; end
        2: begin send_pct = 100; recv_pct = 18;  end
        3: begin send_pct = 88;  recv_pct = 88;  end
        default: begin send_pct = $urandom_range(30, 100); recv_pct = $urandom_range(30, 100); end
      endcase
      sl = (ph % 3 == 0) ? $urandom : $urandom_range(1, 5000);
      fl = (ph % 4 == 0) ? $urandom : $urandom_range(0, 40000);
      set_timetable((ph == 7) ? 64'd0 : ((ph % 2) ? rand64() : 64'($urandom_range(1, 1 << 20))),
                    8'($urandom), sl, fl,
                    (ph % 5 == 4) ? $urandom : 32'($urandom_range(0, sl)));
      base = t_sync + 64'(t_slot) * 64'(t_slen);
      for (int k = 0; k < 100; k++) begin
        case ($urandom_range(4))
          0: now = rand64();
          1: now = t_sync - 64'($urandom_range(0, 1000));
          default: now = base + 64'($urandom_range(0, 3 * ((fl == 0) ? 1 : fl) + 2))
                         - 64'($urandom_range(0, 3));
        endcase
        push_word(now, $urandom_range(9) != 0);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tdma_slot_gate_unit: match");
    end else begin
      $display("tdma_slot_gate_unit: mismatch");
    end
    $finish;
  end
endmodule

### files.f
rtl/core/tsg_pkg.sv
rtl/core/tsg_front.sv
rtl/core/tsg_queue.sv
rtl/core/tsg_back.sv
rtl/core/tdma_slot_gate_unit.sv
tb/tdma_slot_gate_unit_tb.sv
